/* hw/rtl/rgbf_pkg.sv */
// Shared types, constants and the color table for the RGB fade-cycle PWM controller.
// Depends on nothing; rgbf_core and the top module import it.
`timescale 1ns / 1ps

package rgbf_pkg;

  localparam int PWM_BITS_DEF    = 8;
  localparam int TABLE_DEPTH_DEF = 7;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FADE     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD     = 2'd2;

  localparam logic [7:0]  DEBOUNCE_RST = 8'd50;
  localparam logic [7:0]  FADE_RST     = 8'd23;
  localparam logic [15:0] HOLD_RST     = 16'd1000;

  localparam logic [1:0] MODE_CODE_OFF  = 2'd0;
  localparam logic [1:0] MODE_CODE_FADE = 2'd1;
  localparam logic [1:0] MODE_CODE_DARK = 2'd2;

  typedef enum logic [2:0] {
    MODE_OFF  = 3'b001,
    MODE_FADE = 3'b010,
    MODE_DARK = 3'b100
  } mode_t;

  typedef logic [7:0] level_t;
  typedef level_t [2:0] rgb_t;

  localparam level_t LV_ON  = 8'hFF;
  localparam level_t LV_OFF = 8'h00;

  typedef struct packed {
    logic [7:0]  debounce_ticks;
    logic [7:0]  fade_interval;
    logic [15:0] hold_ticks;
  } cfg_t;

  typedef struct packed {
    logic       red_pin;
    logic       green_pin;
    logic       blue_pin;
    logic       fan_pin;
    logic [1:0] mode_now;
    logic [2:0] colour_index;
  } res_t;

  // Entries are written as {blue, green, red}; entries past the seventh are black.
  function automatic rgb_t colour_lookup(input logic [3:0] idx);
    rgb_t c;
    case (idx)
      4'd0:    c = {LV_OFF, LV_OFF, LV_ON};
      4'd1:    c = {LV_OFF, LV_ON,  LV_ON};
      4'd2:    c = {LV_OFF, LV_ON,  LV_OFF};
      4'd3:    c = {LV_ON,  LV_ON,  LV_OFF};
      4'd4:    c = {LV_ON,  LV_OFF, LV_OFF};
      4'd5:    c = {LV_ON,  LV_OFF, LV_ON};
      4'd6:    c = {LV_ON,  LV_ON,  LV_ON};
      default: c = {LV_OFF, LV_OFF, LV_OFF};
    endcase
    return c;
  endfunction

endpackage

/* hw/rtl/rgbf_in_if.sv */
// Tick channel of the RGB fade-cycle PWM controller: valid, ready and one tick word.
// Depends on nothing.
`timescale 1ns / 1ps

interface rgbf_in_if;
  logic valid;
  logic ready;
  logic cmd;
  logic key_level;

  modport source (output valid, output cmd, output key_level, input ready);
  modport sink (input valid, input cmd, input key_level, output ready);
endinterface

/* hw/rtl/rgbf_out_if.sv */
// Result channel of the RGB fade-cycle PWM controller: valid, ready and one status word.
// Depends on nothing.
`timescale 1ns / 1ps

interface rgbf_out_if;
  logic       valid;
  logic       ready;
  logic       red_pin;
  logic       green_pin;
  logic       blue_pin;
  logic       fan_pin;
  logic [1:0] mode_now;
  logic [2:0] colour_index;

  modport source (output valid, output red_pin, output green_pin, output blue_pin,
                  output fan_pin, output mode_now, output colour_index, input ready);
  modport sink (input valid, input red_pin, input green_pin, input blue_pin,
                input fan_pin, input mode_now, input colour_index, output ready);
endinterface

/* hw/rtl/rgbf_cfg_if.sv */
// Register write channel of the RGB fade-cycle PWM controller: valid, ready, index and data.
// Depends on nothing.
`timescale 1ns / 1ps

interface rgbf_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

/* hw/rtl/rgbf_core.sv */
// State registers and next-state logic of the RGB fade-cycle PWM controller.
// Depends on rgbf_pkg; the result word it returns is the state after the current tick.
`timescale 1ns / 1ps

module rgbf_core import rgbf_pkg::*; #(
  parameter int PWM_BITS    = PWM_BITS_DEF,
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic step_en,
  input  logic cmd,
  input  logic key_level,
  input  cfg_t cfg,
  output res_t res_nxt
);

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CMP_W = (PWM_BITS > 8) ? PWM_BITS : 8;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_DEPTH - 1);

  mode_t                mode_r,   mode_nxt;
  logic [7:0]           press_r,  press_nxt;
  rgb_t                 level_r,  level_nxt;
  rgb_t                 target_r, target_nxt;
  logic [IDX_W-1:0]     idx_r,    idx_nxt;
  logic [8:0]           step_r,   step_nxt;
  logic [15:0]          hold_r,   hold_nxt;
  logic [PWM_BITS-1:0]  pwm_r,    pwm_nxt;
  logic [2:0]           pins_r,   pins_nxt;
  logic                 fan_r,    fan_nxt;

  logic [IDX_W-1:0] idx_wrap;
  logic [8:0]       step_inc;
  logic [3:0]       idx_ext;
  logic [1:0]       mode_code;

  assign idx_wrap = (idx_r == IDX_LAST) ? '0 : idx_r + 1'b1;

  always_comb begin
    mode_nxt   = mode_r;
    press_nxt  = press_r;
    level_nxt  = level_r;
    target_nxt = target_r;
    idx_nxt    = idx_r;
    step_nxt   = step_r;
    hold_nxt   = hold_r;
    pwm_nxt    = pwm_r;
    pins_nxt   = pins_r;
    fan_nxt    = fan_r;
    step_inc   = '0;
    if (step_en) begin
      if (cmd) begin
        pwm_nxt = pwm_r + 1'b1;
        for (int c = 0; c < 3; c++) begin
          pins_nxt[c] = ~(CMP_W'(pwm_nxt) < CMP_W'(level_r[c]));
        end
      end else begin
        if (key_level) begin
          press_nxt = '0;
        end else if (press_r < cfg.debounce_ticks) begin
          press_nxt = press_r + 8'd1;
          if (press_nxt == cfg.debounce_ticks) begin
            case (mode_r)
              MODE_OFF: begin
                mode_nxt   = MODE_FADE;
                fan_nxt    = 1'b1;
                target_nxt = colour_lookup(4'(idx_r));
                step_nxt   = {1'b0, cfg.fade_interval};
              end
              MODE_FADE: begin
                mode_nxt  = MODE_DARK;
                level_nxt = '0;
              end
              default: begin
                mode_nxt  = MODE_OFF;
                fan_nxt   = 1'b0;
                level_nxt = '0;
              end
            endcase
          end
        end
        if (mode_nxt == MODE_FADE) begin
          if (hold_r != 16'd0) begin
            hold_nxt = hold_r - 16'd1;
          end else begin
            step_inc = step_nxt + 9'd1;
            if (step_inc <= {1'b0, cfg.fade_interval}) begin
              step_nxt = step_inc;
            end else begin
              step_nxt = '0;
              for (int c = 0; c < 3; c++) begin
                if (level_nxt[c] < target_nxt[c]) begin
                  level_nxt[c] = level_nxt[c] + 8'd1;
                end else if (level_nxt[c] > target_nxt[c]) begin
                  level_nxt[c] = level_nxt[c] - 8'd1;
                end
              end
              if (level_nxt == target_nxt) begin
                idx_nxt    = idx_wrap;
                target_nxt = colour_lookup(4'(idx_wrap));
                hold_nxt   = cfg.hold_ticks;
              end
            end
          end
        end
      end
    end
  end

  always_comb begin
    case (mode_nxt)
      MODE_OFF:  mode_code = MODE_CODE_OFF;
      MODE_FADE: mode_code = MODE_CODE_FADE;
      MODE_DARK: mode_code = MODE_CODE_DARK;
      default:   mode_code = MODE_CODE_OFF;
    endcase
  end

  assign idx_ext = 4'(idx_nxt);

  assign res_nxt.red_pin      = pins_nxt[0];
  assign res_nxt.green_pin    = pins_nxt[1];
  assign res_nxt.blue_pin     = pins_nxt[2];
  assign res_nxt.fan_pin      = fan_nxt;
  assign res_nxt.mode_now     = mode_code;
  assign res_nxt.colour_index = idx_ext[2:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_OFF;
      press_r  <= '0;
      level_r  <= '0;
      target_r <= '0;
      idx_r    <= '0;
      step_r   <= '0;
      hold_r   <= '0;
      pwm_r    <= '0;
      pins_r   <= 3'b111;
      fan_r    <= 1'b0;
    end else begin
      mode_r   <= mode_nxt;
      press_r  <= press_nxt;
      level_r  <= level_nxt;
      target_r <= target_nxt;
      idx_r    <= idx_nxt;
      step_r   <= step_nxt;
      hold_r   <= hold_nxt;
      pwm_r    <= pwm_nxt;
      pins_r   <= pins_nxt;
      fan_r    <= fan_nxt;
    end
  end

  a_fan_follows_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_OFF) == !fan_r)
    else $error("Fan state disagrees with the mode.");

  a_levels_dark: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r != MODE_FADE) |-> (level_r == '0))
    else $error("Levels are not cleared outside fade mode.");

  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= IDX_LAST)
    else $error("Colour index ran past the last table entry.");

  a_pwm_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (step_en && cmd) |=> (pwm_r == $past(pwm_r) + 1'b1))
    else $error("PWM counter did not advance on a PWM tick.");

endmodule

/* hw/rtl/rgb_fade_cycle_pwm_controller.sv */
// RGB fade-cycle PWM controller: one tick word in, one status word out, per cycle while not stalled.
// An accepted word is held in the input register, then stepped through the core into the
// result register. Throughput: one word per cycle; the input stalls only while
// both the input register and a waiting result register are full.
// Reset (rst_n low, synchronous) clears state and pipeline, darkens the LEDs and restores
// the register defaults 50, 23 and 1000. Depends on rgbf_pkg, the interfaces and rgbf_core.
`timescale 1ns / 1ps

module rgb_fade_cycle_pwm_controller import rgbf_pkg::*; #(
  parameter int PWM_BITS    = PWM_BITS_DEF,
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input logic        clk,
  input logic        rst_n,
  rgbf_in_if.sink    in_ch,
  rgbf_out_if.source out_ch,
  rgbf_cfg_if.sink   cfg_ch
);

  cfg_t cfg_r;
  logic s1_vld_r;
  logic s1_cmd_r;
  logic s1_key_r;
  logic out_vld_r;
  res_t out_res_r;
  res_t res_nxt;
  logic out_free;
  logic step_en;
  logic in_acc;

  assign out_free     = !out_vld_r || out_ch.ready;
  assign step_en      = s1_vld_r && out_free;
  assign in_ch.ready  = !s1_vld_r || out_free;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ticks <= DEBOUNCE_RST;
      cfg_r.fade_interval  <= FADE_RST;
      cfg_r.hold_ticks     <= HOLD_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CFG_DEBOUNCE: cfg_r.debounce_ticks <= cfg_ch.data[7:0];
        CFG_FADE:     cfg_r.fade_interval  <= cfg_ch.data[7:0];
        CFG_HOLD:     cfg_r.hold_ticks     <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_vld_r <= 1'b1;
      end else if (step_en) begin
        s1_vld_r <= 1'b0;
      end
      if (step_en) begin
        out_vld_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_cmd_r <= in_ch.cmd;
      s1_key_r <= in_ch.key_level;
    end
    if (step_en) begin
      out_res_r <= res_nxt;
    end
  end

  rgbf_core #(
    .PWM_BITS    (PWM_BITS),
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (step_en),
    .cmd       (s1_cmd_r),
    .key_level (s1_key_r),
    .cfg       (cfg_r),
    .res_nxt   (res_nxt)
  );

  assign out_ch.valid        = out_vld_r;
  assign out_ch.red_pin      = out_res_r.red_pin;
  assign out_ch.green_pin    = out_res_r.green_pin;
  assign out_ch.blue_pin     = out_res_r.blue_pin;
  assign out_ch.fan_pin      = out_res_r.fan_pin;
  assign out_ch.mode_now     = out_res_r.mode_now;
  assign out_ch.colour_index = out_res_r.colour_index;

endmodule
